### rtl/mft_pkg.sv
// Shared types and codes for the message FIFO with truncation.
`timescale 1ns / 1ps

package mft_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [2:0] KIND_STORED   = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_POP_BYTE = 3'd2;
   localparam logic [2:0] KIND_POP_ZERO = 3'd3;
   localparam logic [2:0] KIND_EMPTY    = 3'd4;

   typedef struct packed {
      logic       command;
      logic [7:0] client_id;
      logic       has_byte;
      logic [7:0] data_byte;
      logic       last_item;
      logic [6:0] pop_limit;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] slot_position;
      logic [7:0] owner_id;
      logic [7:0] out_byte;
      logic [6:0] delivered_length;
      logic       final_result;
   } rsp_type;

   typedef struct packed {
      logic push_accept;
      logic pop_accept;
      logic meta_step;
      logic stream_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic queue_empty;
      logic zero_delivery;
      logic stream_last;
   } ctl_sts_type;

endpackage

### rtl/mft_ctrl.sv
// Controller state machine sequencing transfers in and pops out.
`timescale 1ns / 1ps

module mft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_command,
   input  mft_pkg::ctl_sts_type sts,
   output mft_pkg::ctl_cmd_type cmd,
   output logic                 busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_META,
      ST_POP_STREAM
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      cmd.push_accept = accept && (req_command == mft_pkg::CMD_PUSH);
      cmd.pop_accept  = accept && (req_command == mft_pkg::CMD_POP);
      cmd.meta_step   = (state_ff == ST_POP_META);
      cmd.stream_step = (state_ff == ST_POP_STREAM);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.pop_accept && !sts.queue_empty) begin
               state_in = ST_POP_META;
            end
         end
         ST_POP_META: begin
            state_in = sts.zero_delivery ? ST_IDLE : ST_POP_STREAM;
         end
         ST_POP_STREAM: begin
            if (sts.stream_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

endmodule

### rtl/mft_datapath.sv
// Datapath: slot ring pointers, message stores, pop streaming and result register.
`timescale 1ns / 1ps

module mft_datapath #(
   parameter int QUEUE_SLOTS = 8,
   parameter int SLOT_BYTES  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mft_pkg::req_type     req,
   input  mft_pkg::ctl_cmd_type cmd,
   output mft_pkg::ctl_sts_type sts,
   output logic                 rsp_strobe,
   output mft_pkg::rsp_type     rsp_item
);

   localparam int SLOT_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
   localparam int COUNT_W = $clog2(QUEUE_SLOTS + 1);
   localparam int SUM_W   = COUNT_W + 1;
   localparam int LEN_W   = $clog2(SLOT_BYTES + 1);
   localparam int DEPTH   = QUEUE_SLOTS * SLOT_BYTES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(QUEUE_SLOTS - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT  = COUNT_W'(QUEUE_SLOTS);
   localparam logic [SUM_W-1:0]   WRAP_SUM    = SUM_W'(QUEUE_SLOTS);
   localparam logic [LEN_W-1:0]   MAX_LEN     = LEN_W'(SLOT_BYTES);
   localparam logic [ADDR_W-1:0]  SLOT_STRIDE = ADDR_W'(SLOT_BYTES);

   logic [7:0]       payload_mem [DEPTH];
   logic [LEN_W-1:0] length_mem  [QUEUE_SLOTS];
   logic [7:0]       owner_mem   [QUEUE_SLOTS];

   logic [SLOT_W-1:0]  head_ff;
   logic [SLOT_W-1:0]  head_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               push_open_ff;
   logic               push_open_in;
   logic               push_rej_ff;
   logic               push_rej_in;
   logic [LEN_W-1:0]   push_len_ff;
   logic [LEN_W-1:0]   push_len_in;
   logic [SLOT_W-1:0]  push_slot_ff;
   logic [SLOT_W-1:0]  pop_slot_ff;
   logic [6:0]         limit_ff;
   logic [LEN_W-1:0]   len_rd_ff;
   logic [7:0]         own_rd_ff;
   logic [7:0]         pay_rd_ff;
   logic [LEN_W-1:0]   deliver_ff;
   logic [LEN_W-1:0]   idx_ff;
   logic [LEN_W-1:0]   idx_in;
   logic               rsp_strobe_ff;
   logic               rsp_strobe_in;
   mft_pkg::rsp_type   rsp_ff;
   mft_pkg::rsp_type   rsp_in;

   logic               cur_rej;
   logic [SUM_W-1:0]   slot_sum;
   logic [SLOT_W-1:0]  new_slot;
   logic [SLOT_W-1:0]  cur_slot;
   logic [LEN_W-1:0]   cur_len;
   logic [LEN_W-1:0]   len_next;
   logic               byte_wr;
   logic               owner_wr;
   logic               commit;
   logic               pop_go;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic [6:0]         len_wide;
   logic [6:0]         deliver_wide;
   logic [LEN_W-1:0]   deliver_len;

   always_comb begin
      cur_rej  = push_open_ff ? push_rej_ff : (count_ff >= FULL_COUNT);
      slot_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      new_slot = (slot_sum >= WRAP_SUM) ? SLOT_W'(slot_sum - WRAP_SUM) : SLOT_W'(slot_sum);
      cur_slot = push_open_ff ? push_slot_ff : new_slot;
      cur_len  = push_open_ff ? push_len_ff : '0;
      byte_wr  = cmd.push_accept && req.has_byte && !cur_rej && (cur_len < MAX_LEN);
      len_next = byte_wr ? (cur_len + LEN_W'(1)) : cur_len;
      owner_wr = cmd.push_accept && !push_open_ff && !cur_rej;
      commit   = cmd.push_accept && req.last_item && !cur_rej;
      wr_addr  = ADDR_W'(cur_slot) * SLOT_STRIDE + ADDR_W'(cur_len);
      pop_go   = cmd.pop_accept && (count_ff != '0);

      len_wide     = 7'(len_rd_ff);
      deliver_wide = (len_wide < limit_ff) ? len_wide : limit_ff;
      deliver_len  = LEN_W'(deliver_wide);

      sts.queue_empty   = (count_ff == '0);
      sts.zero_delivery = (deliver_len == '0);
      sts.stream_last   = (idx_ff == deliver_ff);

      rd_en   = cmd.meta_step || (cmd.stream_step && !sts.stream_last);
      rd_addr = ADDR_W'(pop_slot_ff) * SLOT_STRIDE + ADDR_W'(idx_ff);
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      push_open_in = push_open_ff;
      push_rej_in  = push_rej_ff;
      push_len_in  = push_len_ff;
      idx_in       = idx_ff;
      if (cmd.push_accept) begin
         if (req.last_item) begin
            push_open_in = 1'b0;
            push_rej_in  = 1'b0;
            push_len_in  = '0;
            if (!cur_rej) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else begin
            push_open_in = 1'b1;
            push_rej_in  = cur_rej;
            push_len_in  = len_next;
         end
      end
      if (pop_go) begin
         head_in  = (head_ff == LAST_SLOT) ? '0 : (head_ff + SLOT_W'(1));
         count_in = count_ff - COUNT_W'(1);
         idx_in   = '0;
      end
      if (cmd.meta_step) begin
         idx_in = LEN_W'(1);
      end
      if (cmd.stream_step && !sts.stream_last) begin
         idx_in = idx_ff + LEN_W'(1);
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      if (cmd.push_accept && req.last_item) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.kind         = cur_rej ? mft_pkg::KIND_REJECTED : mft_pkg::KIND_STORED;
         rsp_in.slot_position = cur_rej ? 3'd0 : 3'(count_ff);
         rsp_in.final_result = 1'b1;
      end
      if (cmd.pop_accept && sts.queue_empty) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.kind         = mft_pkg::KIND_EMPTY;
         rsp_in.final_result = 1'b1;
      end
      if (cmd.meta_step && sts.zero_delivery) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.kind         = mft_pkg::KIND_POP_ZERO;
         rsp_in.owner_id     = own_rd_ff;
         rsp_in.final_result = 1'b1;
      end
      if (cmd.stream_step) begin
         rsp_strobe_in           = 1'b1;
         rsp_in.kind             = mft_pkg::KIND_POP_BYTE;
         rsp_in.owner_id         = own_rd_ff;
         rsp_in.out_byte         = pay_rd_ff;
         rsp_in.delivered_length = 7'(deliver_ff);
         rsp_in.final_result     = sts.stream_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         push_open_ff  <= 1'b0;
         push_rej_ff   <= 1'b0;
         push_len_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         push_open_ff  <= push_open_in;
         push_rej_ff   <= push_rej_in;
         push_len_ff   <= push_len_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      if (cmd.push_accept && !push_open_ff) begin
         push_slot_ff <= new_slot;
      end
      if (cmd.pop_accept) begin
         pop_slot_ff <= head_ff;
         limit_ff    <= req.pop_limit;
         len_rd_ff   <= length_mem[head_ff];
         own_rd_ff   <= owner_mem[head_ff];
      end
      if (cmd.meta_step) begin
         deliver_ff <= deliver_len;
      end
   end

   always_ff @(posedge clock) begin
      if (owner_wr) begin
         owner_mem[cur_slot] <= req.client_id;
      end
      if (commit) begin
         length_mem[cur_slot] <= len_next;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_wr) begin
         payload_mem[wr_addr] <= req.data_byte;
      end
      if (rd_en) begin
         pay_rd_ff <= payload_mem[rd_addr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

### rtl/message_fifo_with_truncation_unit.sv
// Top level of the message FIFO with truncation.
//
// Usage: drive req_item and raise start; a transfer is taken at a rising
// edge with start high and busy low. A push item (command 0) streams one
// message byte if has_byte is set; the item with last_item set commits
// the message and in the next cycle gives a single result: stored with
// its slot position, or rejected when all QUEUE_SLOTS slots were taken
// when the message opened. Bytes beyond SLOT_BYTES are dropped. Push
// items are taken one per cycle while busy is low. A pop (command 1) of
// an empty queue gives one empty result in the next cycle and leaves busy
// low. Otherwise busy stays high through the meta state, which reckons
// n = min(stored length, pop_limit) and gives one result if n is zero,
// then the stream state, one payload byte a cycle from the byte store.
// Results appear for exactly one cycle with rsp_strobe high; the receiver
// cannot stall them. Reset empties the queue and drops any open message;
// the stores themselves keep their contents and need no clearing pass.
`timescale 1ns / 1ps

module message_fifo_with_truncation_unit #(
   parameter int QUEUE_SLOTS = 8,
   parameter int SLOT_BYTES  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mft_pkg::req_type req_item,
   output logic             rsp_strobe,
   output mft_pkg::rsp_type rsp_item
);

   mft_pkg::ctl_cmd_type cmd;
   mft_pkg::ctl_sts_type sts;

   mft_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_item.command),
      .sts         (sts),
      .cmd         (cmd),
      .busy        (busy)
   );

   mft_datapath #(
      .QUEUE_SLOTS (QUEUE_SLOTS),
      .SLOT_BYTES  (SLOT_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

### rtl/mft_checker.sv
// Port-level checker for the message FIFO with truncation, bound to the top level.
`timescale 1ns / 1ps

module mft_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mft_pkg::req_type req_item,
   input logic             rsp_strobe,
   input mft_pkg::rsp_type rsp_item
);

   logic push_take;
   logic pop_take;

   assign push_take = start && !busy && (req_item.command == mft_pkg::CMD_PUSH);
   assign pop_take  = start && !busy && (req_item.command == mft_pkg::CMD_POP);

   a_push_no_busy : assert property (@(posedge clock) disable iff (reset)
      push_take |=> !busy)
      else $error("push transfer raised busy");

   a_commit_result : assert property (@(posedge clock) disable iff (reset)
      push_take && req_item.last_item |=> rsp_strobe && rsp_item.final_result &&
         (rsp_item.kind == mft_pkg::KIND_STORED || rsp_item.kind == mft_pkg::KIND_REJECTED))
      else $error("commit without stored or rejected result");

   a_pop_reply : assert property (@(posedge clock) disable iff (reset)
      pop_take |=> busy || (rsp_strobe && rsp_item.kind == mft_pkg::KIND_EMPTY))
      else $error("pop neither started nor reported empty");

   a_stream_contiguous : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == mft_pkg::KIND_POP_BYTE && !rsp_item.final_result
      |=> rsp_strobe && rsp_item.kind == mft_pkg::KIND_POP_BYTE &&
         $stable(rsp_item.owner_id) && $stable(rsp_item.delivered_length))
      else $error("pop byte stream broken");

endmodule

bind message_fifo_with_truncation_unit mft_checker u_mft_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

### tb/sv/tb.sv
// Self-checking testbench for the message FIFO with truncation unit.
`timescale 1ns / 1ps

module tb;

   localparam int QUEUE_SLOTS = 8;
   localparam int SLOT_BYTES  = 64;
   localparam int SHOW_LIMIT  = 10;

   class message_queue_model;
      logic [7:0]       payload [QUEUE_SLOTS][SLOT_BYTES];
      logic [6:0]       length [QUEUE_SLOTS];
      logic [7:0]       owner [QUEUE_SLOTS];
      int               head_slot;
      int               entry_count;
      bit               push_open;
      int               push_length;
      bit               push_rejected;
      int               push_slot;
      mft_pkg::rsp_type due_results[$];
      int               failures;
      int               results_seen;
      int               kind_seen[8];

      function new();
         head_slot     = 0;
         entry_count   = 0;
         push_open     = 0;
         push_length   = 0;
         push_rejected = 0;
         push_slot     = 0;
         failures      = 0;
         results_seen  = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function void report(string what);
         failures++;
         if (failures <= SHOW_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
      endfunction

      function void take_request(mft_pkg::req_type r);
         mft_pkg::rsp_type e;
         int               slot;
         int               n;
         e = '0;
         e.final_result = 1'b1;
         if (r.command == mft_pkg::CMD_PUSH) begin
            if (!push_open) begin
               push_open     = 1;
               push_length   = 0;
               push_rejected = (entry_count >= QUEUE_SLOTS);
               if (!push_rejected) begin
                  push_slot        = (head_slot + entry_count) % QUEUE_SLOTS;
                  owner[push_slot] = r.client_id;
               end
            end
            if (r.has_byte && !push_rejected && push_length < SLOT_BYTES) begin
               payload[push_slot][push_length] = r.data_byte;
               push_length++;
            end
            if (r.last_item) begin
               push_open = 0;
               if (push_rejected) begin
                  push_rejected = 0;
                  e.kind = mft_pkg::KIND_REJECTED;
               end else begin
                  length[push_slot] = 7'(push_length);
                  e.kind            = mft_pkg::KIND_STORED;
                  e.slot_position   = 3'(entry_count);
                  entry_count++;
               end
               push_length = 0;
               due_results.push_back(e);
            end
         end else if (entry_count == 0) begin
            e.kind = mft_pkg::KIND_EMPTY;
            due_results.push_back(e);
         end else begin
            slot = head_slot;
            n    = (length[slot] < r.pop_limit) ? length[slot] : r.pop_limit;
            if (n > SLOT_BYTES) n = SLOT_BYTES;
            head_slot = (slot + 1) % QUEUE_SLOTS;
            entry_count--;
            e.owner_id = owner[slot];
            if (n == 0) begin
               e.kind = mft_pkg::KIND_POP_ZERO;
               due_results.push_back(e);
            end else begin
               for (int i = 0; i < n; i++) begin
                  e.kind             = mft_pkg::KIND_POP_BYTE;
                  e.out_byte         = payload[slot][i];
                  e.delivered_length = 7'(n);
                  e.final_result     = (i == n - 1);
                  due_results.push_back(e);
               end
            end
         end
      endfunction

      function void check_result(mft_pkg::rsp_type a);
         mft_pkg::rsp_type e;
         results_seen++;
         kind_seen[a.kind]++;
         if (due_results.size() == 0) begin
            report($sformatf("result with nothing due: kind %0d byte %02h",
                             a.kind, a.out_byte));
            return;
         end
         e = due_results.pop_front();
         if (a.kind !== e.kind || a.slot_position !== e.slot_position ||
             a.owner_id !== e.owner_id || a.out_byte !== e.out_byte ||
             a.delivered_length !== e.delivered_length ||
             a.final_result !== e.final_result)
            report($sformatf({"mismatch: exp kind %0d pos %0d owner %02h byte %02h len %0d",
                              " fin %0d, got kind %0d pos %0d owner %02h byte %02h len %0d",
                              " fin %0d"},
                             e.kind, e.slot_position, e.owner_id, e.out_byte,
                             e.delivered_length, e.final_result,
                             a.kind, a.slot_position, a.owner_id, a.out_byte,
                             a.delivered_length, a.final_result));
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   mft_pkg::req_type req_item;
   logic             rsp_strobe;
   mft_pkg::rsp_type rsp_item;

   message_queue_model queue_model;
   mft_pkg::req_type   stim_items[$];
   int                 transfers;

   message_fifo_with_truncation_unit #(
      .QUEUE_SLOTS(QUEUE_SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) queue_model.check_result(rsp_item);
   end

   function automatic logic [6:0] pick_limit();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 7'd0;
      if (r <= 2) return 7'd64;
      return 7'($urandom_range(64));
   endfunction

   task automatic add_item(logic cmd, logic [7:0] client, logic hb, logic [7:0] data,
                           logic last, logic [6:0] limit);
      mft_pkg::req_type r;
      r.command   = cmd;
      r.client_id = client;
      r.has_byte  = hb;
      r.data_byte = data;
      r.last_item = last;
      r.pop_limit = limit;
      stim_items.push_back(r);
   endtask

   task automatic add_pop(logic [6:0] limit);
      add_item(mft_pkg::CMD_POP, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
               limit);
   endtask

   task automatic add_message(int n_items, bit all_bytes);
      logic hb;
      for (int i = 0; i < n_items; i++) begin
         hb = all_bytes ? 1'b1 : ($urandom_range(99) < 85);
         if (i < n_items - 1 && $urandom_range(99) < 5) add_pop(pick_limit());
         add_item(mft_pkg::CMD_PUSH, 8'($urandom), hb, 8'($urandom), i == n_items - 1,
                  7'($urandom_range(64)));
      end
   endtask

   task automatic add_traffic(int budget, int pop_pct);
      int r;
      while (stim_items.size() < budget) begin
         if ($urandom_range(99) < pop_pct) begin
            add_pop(pick_limit());
         end else begin
            r = $urandom_range(99);
            if (r < 80)      add_message($urandom_range(1, 6), 0);
            else if (r < 97) add_message($urandom_range(7, 20), 0);
            else             add_message($urandom_range(60, 70), 0);
         end
      end
   endtask

   task automatic send_items(int idle_pct);
      while (stim_items.size() > 0 || start) begin
         @(posedge clock);
         if (start && !busy) begin
            queue_model.take_request(req_item);
            transfers++;
         end else if (start) begin
            continue;
         end
         if (stim_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_item <= stim_items.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int waited;
      queue_model = new();
      transfers   = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_item(mft_pkg::CMD_POP, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0);
      add_item(mft_pkg::CMD_PUSH, 8'hFF, 1'b1, 8'hFF, 1'b0, 7'd64);
      add_item(mft_pkg::CMD_PUSH, 8'h00, 1'b1, 8'h00, 1'b0, 7'd0);
      add_item(mft_pkg::CMD_PUSH, 8'h5A, 1'b1, 8'hA5, 1'b1, 7'd0);
      add_item(mft_pkg::CMD_PUSH, 8'h00, 1'b0, 8'h00, 1'b1, 7'd0);
      for (int k = 0; k < 6; k++)
         add_item(mft_pkg::CMD_PUSH, 8'(k * 37 + 1), 1'b1, 8'(k * 41 + 7), 1'b1, 7'd0);
      add_item(mft_pkg::CMD_PUSH, 8'h77, 1'b1, 8'hEE, 1'b0, 7'd0);
      add_item(mft_pkg::CMD_PUSH, 8'h77, 1'b0, 8'h00, 1'b1, 7'd0);
      add_item(mft_pkg::CMD_POP, 8'hFF, 1'b1, 8'hFF, 1'b1, 7'd2);
      add_item(mft_pkg::CMD_POP, 8'h00, 1'b0, 8'h00, 1'b0, 7'd5);
      add_item(mft_pkg::CMD_POP, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0);
      add_item(mft_pkg::CMD_PUSH, 8'h3C, 1'b1, 8'hC3, 1'b0, 7'd0);
      add_item(mft_pkg::CMD_POP, 8'h00, 1'b0, 8'h00, 1'b0, 7'd1);
      add_item(mft_pkg::CMD_PUSH, 8'h81, 1'b1, 8'h99, 1'b1, 7'd0);
      send_items(0);

      add_traffic(60, 30);
      for (int k = 0; k < QUEUE_SLOTS; k++) add_pop(pick_limit());
      add_message(70, 1);
      add_pop(7'd64);
      send_items(0);

      add_traffic(60, 55);
      send_items(73);

      add_traffic(60, 40);
      send_items(22);

      waited = 0;
      while (queue_model.due_results.size() > 0 && waited < 400) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (queue_model.due_results.size() > 0)
         queue_model.report($sformatf("%0d results never arrived",
                                      queue_model.due_results.size()));

      $display("Run covered %0d request transfers and %0d checked results in four phases.",
               transfers, queue_model.results_seen);
      $display("Seen: %0d stored, %0d rejected, %0d bytes popped, %0d zero, %0d empty; %0d errors.",
               queue_model.kind_seen[mft_pkg::KIND_STORED],
               queue_model.kind_seen[mft_pkg::KIND_REJECTED],
               queue_model.kind_seen[mft_pkg::KIND_POP_BYTE],
               queue_model.kind_seen[mft_pkg::KIND_POP_ZERO],
               queue_model.kind_seen[mft_pkg::KIND_EMPTY], queue_model.failures);
      if (queue_model.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mft_pkg.sv
rtl/mft_ctrl.sv
rtl/mft_datapath.sv
rtl/message_fifo_with_truncation_unit.sv
rtl/mft_checker.sv
tb/sv/tb.sv
